[sv/rdi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_pkg
// shared types and constants of the ray/disk intersection pipeline
// ----------------------------------------------------------------------------
package rdi_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_RADIUS   = 3'd6,
    REG_EPSILON  = 3'd7
  } reg_idx_t;

  localparam logic signed [31:0] NormalZReset = 32'sd65536;
  localparam logic [15:0]        EpsilonReset = 16'd1;

  typedef logic signed [31:0] q16_t;

  // saturate a wide signed value to 32 bits
  function automatic q16_t sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

[sv/ray_disk_intersection_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_disk_intersection_unit
// pipelined ray/disk intersection test in Q16.16 fixed point
// ----------------------------------------------------------------------------
// channel  direction  handshake      payload
// in_      input      valid / stall  origin_x/y/z, dir_x/y/z
// out_     output     valid / stall  hit, facing, hit_distance, hit_x/y/z
// cfg_     input      valid / ready  index (3 bit), data (32 bit)
//
// one item enters per cycle while out_stall is low; the pipeline includes the
// restoring divider that resolves one quotient bit per stage.
// rst_n clears all valid bits and loads the register reset values.
// out_stall freezes the whole pipeline; cfg_ready is always high.
// ----------------------------------------------------------------------------
module ray_disk_intersection_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rdi_pkg::q16_t       in_origin_x,
  input  rdi_pkg::q16_t       in_origin_y,
  input  rdi_pkg::q16_t       in_origin_z,
  input  rdi_pkg::q16_t       in_dir_x,
  input  rdi_pkg::q16_t       in_dir_y,
  input  rdi_pkg::q16_t       in_dir_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic                out_facing,
  output rdi_pkg::q16_t       out_hit_distance,
  output rdi_pkg::q16_t       out_hit_x,
  output rdi_pkg::q16_t       out_hit_y,
  output rdi_pkg::q16_t       out_hit_z,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rdi_pkg::*;

  localparam int DivBits = 32;   // quotient bits: 31 magnitude + overflow
  localparam int DW      = 67;   // dot product width (signed)
  localparam int NW      = 83;   // shifted numerator magnitude width

  // configuration
  q16_t cx_r, cy_r, cz_r, nx_r, ny_r, nz_r;
  logic [30:0] rad_r;
  logic [15:0] eps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
      nx_r <= '0; ny_r <= '0; nz_r <= NormalZReset;
      rad_r <= '0; eps_r <= EpsilonReset;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CENTER_X: cx_r  <= cfg_data;
        REG_CENTER_Y: cy_r  <= cfg_data;
        REG_CENTER_Z: cz_r  <= cfg_data;
        REG_NORMAL_X: nx_r  <= cfg_data;
        REG_NORMAL_Y: ny_r  <= cfg_data;
        REG_NORMAL_Z: nz_r  <= cfg_data;
        REG_RADIUS:   rad_r <= cfg_data[30:0];
        REG_EPSILON:  eps_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_stall;
  assign in_stall = out_stall;

  // stage 1: products
  logic                v1_r;
  q16_t                o1_r [3];
  q16_t                d1_r [3];
  logic signed [63:0]  pd1_r [3];
  logic signed [64:0]  pn1_r [3];
  q16_t                oin [3];
  q16_t                din [3];
  q16_t                cv [3];
  q16_t                nv [3];

  assign oin = '{in_origin_x, in_origin_y, in_origin_z};
  assign din = '{in_dir_x, in_dir_y, in_dir_z};
  assign cv  = '{cx_r, cy_r, cz_r};
  assign nv  = '{nx_r, ny_r, nz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        o1_r[i]  <= oin[i];
        d1_r[i]  <= din[i];
        pd1_r[i] <= din[i] * nv[i];
        pn1_r[i] <= nv[i] * ($signed({cv[i][31], cv[i]}) - $signed({oin[i][31], oin[i]}));
      end
    end
  end

  // stage 2: dot products, facing, operand magnitudes
  logic               v2_r, f2_r, neg2_r;
  q16_t               o2_r [3];
  q16_t               d2_r [3];
  logic [NW-1:0]      nm2_r;
  logic [DW-1:0]      dm2_r;
  logic signed [DW-1:0] dt_s, num_s;

  always_comb begin
    dt_s  = DW'(pd1_r[0]) + DW'(pd1_r[1]) + DW'(pd1_r[2]);
    num_s = DW'(pn1_r[0]) + DW'(pn1_r[1]) + DW'(pn1_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o2_r   <= o1_r;
      d2_r   <= d1_r;
      f2_r   <= (dt_s + $signed({35'd0, eps_r, 16'd0})) <= 0;
      neg2_r <= num_s[DW-1] != dt_s[DW-1];
      nm2_r  <= {NW'(num_s[DW-1] ? -num_s : num_s)} << 16;
      dm2_r  <= dt_s[DW-1] ? DW'(-dt_s) : DW'(dt_s);
    end
  end

  // divider stages: stage k decides quotient bit DivBits-1-k
  logic               dv_r  [DivBits+1];
  logic               df_r  [DivBits+1];
  logic               dn_r  [DivBits+1];
  logic [NW-1:0]      drem_r [DivBits+1];
  logic [DW-1:0]      dden_r [DivBits+1];
  logic [DivBits-1:0] dq_r  [DivBits+1];
  q16_t               do_r  [DivBits+1][3];
  q16_t               dd_r  [DivBits+1][3];

  always_comb begin
    dv_r[0]   = v2_r;
    df_r[0]   = f2_r;
    dn_r[0]   = neg2_r;
    drem_r[0] = nm2_r;
    dden_r[0] = dm2_r;
    dq_r[0]   = '0;
    do_r[0]   = o2_r;
    dd_r[0]   = d2_r;
  end

  for (genvar k = 0; k < DivBits; k++) begin : g_div
    localparam int Sh = DivBits - 1 - k;
    logic [NW+DivBits-1:0] sub;
    logic                  ge;
    assign sub = {{DivBits{1'b0}}, (NW)'(dden_r[k])} << Sh;
    assign ge  = {{DivBits{1'b0}}, drem_r[k]} >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else if (adv) dv_r[k+1] <= dv_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        df_r[k+1]   <= df_r[k];
        dn_r[k+1]   <= dn_r[k];
        dden_r[k+1] <= dden_r[k];
        do_r[k+1]   <= do_r[k];
        dd_r[k+1]   <= dd_r[k];
        drem_r[k+1] <= ge ? NW'(drem_r[k] - sub[NW-1:0]) : drem_r[k];
        dq_r[k+1]   <= dq_r[k] | (DivBits'(ge) << Sh);
      end
    end
  end

  // stage a: signed, saturated t
  logic  va_r, fa_r;
  q16_t  ta_r;
  q16_t  oa_r [3];
  q16_t  da_r [3];
  logic signed [65:0] tm_s;

  always_comb begin
    // overflow bit set means magnitude >= 2^31
    tm_s = dq_r[DivBits][DivBits-1] ? 66'sd2147483648 : $signed({34'd0, dq_r[DivBits]});
    if (dn_r[DivBits]) tm_s = -tm_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= dv_r[DivBits];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fa_r <= df_r[DivBits];
      ta_r <= sat32(tm_s);
      oa_r <= do_r[DivBits];
      da_r <= dd_r[DivBits];
    end
  end

  // stage b: t * d products
  logic  vb_r, fb_r;
  q16_t  tb_r;
  q16_t  ob_r [3];
  logic signed [63:0] pb_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fb_r <= fa_r;
      tb_r <= ta_r;
      ob_r <= oa_r;
      for (int i = 0; i < 3; i++) pb_r[i] <= ta_r * da_r[i];
    end
  end

  // stage c: hit point and offset from center
  logic  vc_r, fc_r;
  q16_t  tc_r;
  q16_t  pc_r [3];
  logic [32:0] mc_r [3];
  q16_t  pn [3];
  logic signed [33:0] df [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pn[i] = sat32(66'($signed(ob_r[i])) + 66'($signed(pb_r[i][63:16])));
      df[i] = $signed({pn[i][31], pn[i]}) - $signed({cv[i][31], cv[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fc_r <= fb_r;
      tc_r <= tb_r;
      pc_r <= pn;
      for (int i = 0; i < 3; i++) mc_r[i] <= 33'(df[i][33] ? -df[i] : df[i]);
    end
  end

  // stage e: squares
  logic  ve_r, fe_r, ine_r;
  q16_t  te_r;
  q16_t  pe_r [3];
  logic [61:0] sqe_r [3];
  logic [61:0] r2e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else if (adv) ve_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fe_r  <= fc_r;
      te_r  <= tc_r;
      pe_r  <= pc_r;
      ine_r <= (mc_r[0] <= 33'(rad_r)) && (mc_r[1] <= 33'(rad_r))
               && (mc_r[2] <= 33'(rad_r));
      r2e_r <= rad_r * rad_r;
      for (int i = 0; i < 3; i++)
        sqe_r[i] <= 62'(mc_r[i][30:0]) * 62'(mc_r[i][30:0]);
    end
  end

  // output register
  logic  vo_r, ho_r, fo_r;
  q16_t  to_r, xo_r, yo_r, zo_r;
  logic [63:0] sq_sum;

  assign sq_sum = 64'(sqe_r[0]) + 64'(sqe_r[1]) + 64'(sqe_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (adv) vo_r <= ve_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fo_r <= fe_r;
      ho_r <= fe_r && ine_r && (sq_sum <= 64'(r2e_r));
      to_r <= fe_r ? te_r : '0;
      xo_r <= fe_r ? pe_r[0] : '0;
      yo_r <= fe_r ? pe_r[1] : '0;
      zo_r <= fe_r ? pe_r[2] : '0;
    end
  end

  assign out_valid        = vo_r;
  assign out_hit          = ho_r;
  assign out_facing       = fo_r;
  assign out_hit_distance = to_r;
  assign out_hit_x        = xo_r;
  assign out_hit_y        = yo_r;
  assign out_hit_z        = zo_r;

endmodule

[sv/rdi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_checker
// port level checks of the ray/disk intersection pipeline
// ----------------------------------------------------------------------------
module rdi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic        out_facing,
  input logic [31:0] out_hit_distance,
  input logic [31:0] out_hit_x,
  input logic        cfg_ready
);

  // a hit needs a facing ray
  a_hit_facing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_facing) else $error("hit without facing");

  // rejected rays report zero distance and zero hit_x
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_facing |-> out_hit_distance == '0 && out_hit_x == '0)
    else $error("nonzero payload on rejected item");

  // input stalls exactly when output stalls
  a_stall_link: assert property (@(posedge clk) in_stall == out_stall)
    else $error("stall mismatch");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config not ready");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_x))
    else $error("stalled item changed");

endmodule

bind ray_disk_intersection_unit rdi_checker u_rdi_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_hit(out_hit), .out_facing(out_facing),
  .out_hit_distance(out_hit_distance), .out_hit_x(out_hit_x), .cfg_ready(cfg_ready)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ray/disk intersection unit: bursty rays,
// receiver stall pattern, scoreboard model, disk rewritten between phases
// ----------------------------------------------------------------------------
module tb;
  import rdi_pkg::*;

  typedef struct {
    logic hit;
    logic facing;
    q16_t distance;
    q16_t px;
    q16_t py;
    q16_t pz;
  } isect_t;

  class isect_scoreboard;
    q16_t        center [3];
    q16_t        normal [3];
    logic [30:0] radius;
    logic [15:0] eps;
    isect_t      pending [$];
    int          errors;

    function new();
      center = '{0, 0, 0};
      normal = '{0, 0, NormalZReset};
      radius = '0;
      eps    = EpsilonReset;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_CENTER_X: center[0] = v;
        REG_CENTER_Y: center[1] = v;
        REG_CENTER_Z: center[2] = v;
        REG_NORMAL_X: normal[0] = v;
        REG_NORMAL_Y: normal[1] = v;
        REG_NORMAL_Z: normal[2] = v;
        REG_RADIUS:   radius = v[30:0];
        REG_EPSILON:  eps = v[15:0];
        default: ;
      endcase
    endfunction

    function q16_t clamp(logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_ray(q16_t o [3], q16_t d [3]);
      logic signed [127:0] dt, num, chk;
      logic [127:0] nm, dm, sq, rr;
      logic signed [65:0] tm, t66, pw;
      logic signed [63:0] prod;
      logic signed [33:0] diff;
      logic [63:0] m;
      q16_t t;
      q16_t p [3];
      isect_t e;
      dt = 0;
      num = 0;
      for (int i = 0; i < 3; i++) begin
        dt  = dt + $signed(d[i]) * $signed(normal[i]);
        num = num + $signed(normal[i]) * ($signed(center[i]) - $signed(o[i]));
      end
      chk = dt + 128'(eps) * 65536;
      if (!chk[127] && chk != 0) begin
        e = '{1'b0, 1'b0, 0, 0, 0, 0};
        pending.push_back(e);
        return;
      end
      nm = (num[127] ? -num : num) << 16;
      dm = dt[127] ? -dt : dt;
      if (nm >= (dm << 31)) tm = 66'sd2147483648;
      else tm = 66'(nm / dm);
      t66 = (num[127] != dt[127]) ? -tm : tm;
      t = clamp(t66);
      for (int i = 0; i < 3; i++) begin
        prod = t * d[i];
        pw = o[i] + (prod >>> 16);
        p[i] = clamp(pw);
      end
      e.hit = 1'b1;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        diff = $signed(p[i]) - $signed(center[i]);
        m = diff[33] ? 64'(-diff) : 64'(diff);
        if (m > 64'(radius)) e.hit = 1'b0;
        else sq = sq + 128'(m) * 128'(m);
      end
      rr = 128'(radius) * 128'(radius);
      if (e.hit && sq > rr) e.hit = 1'b0;
      e.facing = 1'b1;
      e.distance = t;
      e.px = p[0];
      e.py = p[1];
      e.pz = p[2];
      pending.push_back(e);
    endfunction

    function void check_result(isect_t a);
      isect_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item hit=%0d facing=%0d t=%0d", $time,
                 a.hit, a.facing, a.distance);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit) begin
        $display("%0t: hit exp %0d act %0d", $time, e.hit, a.hit);
        errors++;
      end
      if (a.facing !== e.facing) begin
        $display("%0t: facing exp %0d act %0d", $time, e.facing, a.facing);
        errors++;
      end
      if (a.distance !== e.distance) begin
        $display("%0t: hit_distance exp %0d act %0d", $time, e.distance, a.distance);
        errors++;
      end
      if (a.px !== e.px) begin
        $display("%0t: hit_x exp %0d act %0d", $time, e.px, a.px);
        errors++;
      end
      if (a.py !== e.py) begin
        $display("%0t: hit_y exp %0d act %0d", $time, e.py, a.py);
        errors++;
      end
      if (a.pz !== e.pz) begin
        $display("%0t: hit_z exp %0d act %0d", $time, e.pz, a.pz);
        errors++;
      end
    endfunction
  endclass

  localparam int DrainCycles = 80;
  localparam int CycleLimit  = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  q16_t in_origin_x = 0, in_origin_y = 0, in_origin_z = 0;
  q16_t in_dir_x = 0, in_dir_y = 0, in_dir_z = 0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit, out_facing;
  q16_t out_hit_distance, out_hit_x, out_hit_y, out_hit_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  isect_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  always #1 clk = ~clk;

  ray_disk_intersection_unit DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver stall pattern, mode redrawn at random from four stall densities
  always @(posedge clk) begin
    if (cycles % 150 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_hit, out_facing, out_hit_distance, out_hit_x,
                        out_hit_y, out_hit_z});
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_ray(q16_t o [3], q16_t d [3]);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_origin_x <= o[0];
    in_origin_y <= o[1];
    in_origin_z <= o[2];
    in_dir_x <= d[0];
    in_dir_y <= d[1];
    in_dir_z <= d[2];
    do @(posedge clk); while (in_stall);
    sb.note_ray(o, d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic q16_t small_val(int r);
    return $signed($urandom_range(0, 2 * r)) - r;
  endfunction

  // ray aimed near the disk, usually facing it, or a fully random ray
  task automatic random_ray();
    q16_t o [3];
    q16_t d [3];
    longint dot;
    int k;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = $urandom;
        d[i] = $urandom;
      end
    end else begin
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = small_val(3 * 65536);
        dot += longint'(d[i]) * longint'(sb.normal[i]);
      end
      if (dot > 0 && $urandom_range(0, 9) != 0)
        for (int i = 0; i < 3; i++) d[i] = -d[i];
      k = $urandom_range(0, 5);
      for (int i = 0; i < 3; i++)
        o[i] = sb.center[i] + small_val(int'(sb.radius) + 65536) - k * d[i];
    end
    send_ray(o, d);
  endtask

  task automatic disk(q16_t cx, q16_t cy, q16_t cz, q16_t nx, q16_t ny, q16_t nz,
                      logic [31:0] r, logic [31:0] e);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_RADIUS, r);
    write_reg(REG_EPSILON, e);
  endtask

  initial begin
    q16_t mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset disk: point at origin, normal +z
    send_ray('{0, 0, 5 * 65536}, '{0, 0, -65536});
    send_ray('{65536, 0, 5 * 65536}, '{0, 0, -65536});
    send_ray('{0, 0, 65536}, '{0, 0, 65536});
    send_ray('{0, 0, 0}, '{0, 0, 0});
    send_ray('{0, 0, 65536}, '{0, 0, -1});
    send_ray('{mx, mx, mx}, '{mn, mn, mn});
    send_ray('{mn, mn, mn}, '{mx, mx, mn});
    send_ray('{mx, mn, mx}, '{mn, mx, -1});
    send_ray('{-65536, 0, 2 * 65536}, '{65536, 0, -65536});
    send_ray('{0, 0, mx}, '{0, 0, -1});
    drain();

    disk(65536, -65536, 0, 0, 0, 65536, 2 * 65536, 0);
    send_ray('{65536, -65536, 65536}, '{0, 0, -65536});
    send_ray('{0, 0, 65536}, '{65536, 0, 0});
    send_ray('{3 * 65536, -65536, 65536}, '{0, 0, -65536});
    send_ray('{65536, 65536, 65536}, '{0, 0, -65536});
    send_ray('{65536, -65536, -65536}, '{0, 0, -65536});
    send_ray('{65536, -65536, 65536}, '{-65536, 0, -65536});
    repeat (60) random_ray();
    drain();

    disk(mx, mn, mx, mn, mx, mn, 32'h7fffffff, 16'hffff);
    send_ray('{mn, mx, mn}, '{mx, mn, mx});
    send_ray('{0, 0, 0}, '{mx, mn, mx});
    send_ray('{mx, mx, mx}, '{mn, mn, mn});
    repeat (50) random_ray();
    drain();

    disk(mn, mx, mn, mx, mn, mx, 0, 16'hffff);
    repeat (50) random_ray();
    drain();

    disk(3 * 65536, 2 * 65536, -65536, 65536, 0, 0, 3 * 65536, 1);
    repeat (70) random_ray();
    drain();

    disk(-5 * 65536, 7 * 65536, 2 * 65536, 40000, -40000, 20000, 4 * 65536, 300);
    repeat (70) random_ray();
    drain();

    disk(0, 0, 0, 0, 65536, 0, 65536, 65535);
    repeat (60) random_ray();
    drain();

    disk(123, -456, 789, 1, -2, 3, 32'h7fffffff, 0);
    repeat (50) random_ray();
    drain();

    disk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (50) random_ray();
    drain();

    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/rdi_pkg.sv
sv/ray_disk_intersection_unit.sv
sv/rdi_checker.sv
dv/tb.sv
